// File: hdl/spc_pkg.sv
// Shared types, constants and row-mixing functions for the seeded parity-check syndrome block.
package spc_pkg;

	localparam int WORD_W = 32;
	localparam int SYN_W = 16;
	localparam int ROW_COUNT_DEF = 16;
	localparam int REVOLVE_STEPS_DEF = 8;

	typedef logic [WORD_W-1:0] word_t;
	typedef logic [SYN_W-1:0] syn_t;

	typedef enum logic [1:0] {
		GEN_LOAD,
		GEN_STEP,
		GEN_IDLE
	} gen_state_t;

	function automatic word_t rol1(input word_t x);
		return {x[30:0], x[31]};
	endfunction

	function automatic word_t ror1(input word_t x);
		return {x[0], x[31:1]};
	endfunction

	function automatic word_t rol4(input word_t x);
		return {x[27:0], x[31:28]};
	endfunction

	function automatic word_t rol8(input word_t x);
		return {x[23:0], x[31:24]};
	endfunction

	function automatic word_t mix(input word_t a, input word_t b);
		return a ^ b ^ rol1(a) ^ rol1(b) ^ ror1(a) ^ ror1(b);
	endfunction

	// One revolve step of the row generator; the add wraps at 32 bits.
	function automatic word_t revolve(input word_t a, input word_t seed);
		word_t sum;
		sum = a + seed;
		return mix(a, seed) ^ rol8(sum);
	endfunction

endpackage

// File: hdl/spc_row_gen.sv
// Row generator: holds the seed, rebuilds the row table one revolve step per cycle.
module spc_row_gen
	import spc_pkg::*;
#(
	parameter int ROW_COUNT = ROW_COUNT_DEF,
	parameter int REVOLVE_STEPS = REVOLVE_STEPS_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  cfg_we,
	input  word_t cfg_seed,
	output logic  busy,
	output word_t rows [ROW_COUNT]
);

	localparam int RW = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
	localparam int SW = (REVOLVE_STEPS > 1) ? $clog2(REVOLVE_STEPS) : 1;

	gen_state_t state_q, state_d;
	logic [RW-1:0] row_q;
	logic [SW-1:0] step_q;
	word_t seed_q;
	word_t acc_q;
	word_t acc_nxt;
	word_t rows_q [ROW_COUNT];
	logic last_step, last_row;
	logic do_load, do_step, adv_row;

	assign acc_nxt = revolve(acc_q, seed_q);
	assign last_step = (step_q == SW'(REVOLVE_STEPS - 1));
	assign last_row = (row_q == RW'(ROW_COUNT - 1));

	always_comb begin
		state_d = state_q;
		if (cfg_we) begin
			state_d = GEN_LOAD;
		end else begin
			case (state_q)
				GEN_LOAD: state_d = GEN_STEP;
				GEN_STEP: begin
					if (last_step) begin
						state_d = last_row ? GEN_IDLE : GEN_LOAD;
					end
				end
				GEN_IDLE: state_d = GEN_IDLE;
				default:  state_d = GEN_IDLE;
			endcase
		end
	end

	always_comb begin
		do_load = (state_q == GEN_LOAD) && !cfg_we;
		do_step = (state_q == GEN_STEP) && !cfg_we;
		adv_row = do_step && last_step && !last_row;
		busy = (state_q != GEN_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= GEN_LOAD;
			row_q <= '0;
			step_q <= '0;
			seed_q <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				seed_q <= cfg_seed;
				row_q <= '0;
			end else if (adv_row) begin
				row_q <= row_q + 1'b1;
			end
			if (do_load) begin
				step_q <= '0;
			end else if (do_step) begin
				step_q <= step_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_load) begin
			acc_q <= rol4(seed_q ^ {{(WORD_W - RW){1'b0}}, row_q});
		end else if (do_step) begin
			acc_q <= acc_nxt;
		end
		// store the row on its final revolve step
		if (do_step && last_step) begin
			rows_q[row_q] <= acc_nxt;
		end
	end

	assign rows = rows_q;

endmodule

// File: hdl/spc_syndrome.sv
// Syndrome datapath: input register, AND-parity per row, result register.
module spc_syndrome
	import spc_pkg::*;
#(
	parameter int ROW_COUNT = ROW_COUNT_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  hold,
	input  word_t rows [ROW_COUNT],
	input  logic  in_valid,
	output logic  in_stall,
	input  word_t error_vector,
	output logic  out_valid,
	input  logic  out_stall,
	output syn_t  syndrome
);

	localparam int SYN_ROWS = (ROW_COUNT < SYN_W) ? ROW_COUNT : SYN_W;

	logic valid_s1, valid_s2;
	word_t ev_s1;
	syn_t syn_s2;
	syn_t syn_c;
	logic load_s2, load_s1;

	genvar gi;
	generate
		for (gi = 0; gi < SYN_W; gi++) begin : g_bit
			if (gi < SYN_ROWS) begin : g_row
				assign syn_c[gi] = ^(rows[gi] & ev_s1);
			end else begin : g_none
				assign syn_c[gi] = 1'b0;
			end
		end
	endgenerate

	assign load_s2 = !valid_s2 || !out_stall;
	assign load_s1 = !valid_s1 || load_s2;
	assign in_stall = hold || !load_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (load_s1) begin
				valid_s1 <= in_valid && !in_stall;
			end
			if (load_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			ev_s1 <= error_vector;
		end
		if (load_s2 && valid_s1) begin
			syn_s2 <= syn_c;
		end
	end

	assign out_valid = valid_s2;
	assign syndrome = syn_s2;

endmodule

// File: hdl/seeded_parity_check_syndrome.sv
// Top level of the seeded parity-check syndrome block.
// Takes one 32-bit error vector per cycle while in_stall is low and returns its 16-bit
// syndrome through the input register, then the result register; bit i is the parity
// of row i AND the vector. The rows come from matrix_seed through a generator that runs
// one revolve step per cycle; after reset and after each seed write it rebuilds the
// table, during which in_stall stays high. Seed writes are always taken and restart
// the rebuild.
module seeded_parity_check_syndrome
	import spc_pkg::*;
#(
	parameter int ROW_COUNT = ROW_COUNT_DEF,
	parameter int REVOLVE_STEPS = REVOLVE_STEPS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_stall,
	input  logic [31:0]  error_vector,
	output logic         out_valid,
	input  logic         out_stall,
	output logic [15:0]  syndrome,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [31:0]  matrix_seed
);

	logic busy;
	word_t rows [ROW_COUNT];

	assign cfg_ready = 1'b1;

	spc_row_gen #(
		.ROW_COUNT(ROW_COUNT),
		.REVOLVE_STEPS(REVOLVE_STEPS)
	) u_row_gen (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_valid && cfg_ready),
		.cfg_seed(matrix_seed),
		.busy(busy),
		.rows(rows)
	);

	spc_syndrome #(
		.ROW_COUNT(ROW_COUNT)
	) u_syndrome (
		.clk(clk),
		.arst_n(arst_n),
		.hold(busy),
		.rows(rows),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.error_vector(error_vector),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.syndrome(syndrome)
	);

endmodule

// File: tb/sv/testbench.sv
// Self-checking testbench for the seeded parity-check syndrome block.
`timescale 1ns / 1ps

module testbench;
	import spc_pkg::*;

	localparam int CLK_HALF = 6;
	localparam int CYCLE_LIMIT = 400000;
	localparam int TAIL_CYCLES = 8;
	localparam int RANDOM_ITEMS = 1350;
	localparam int SEED_EVERY = 90;

	typedef struct {
		word_t vec;
		syn_t syn;
	} syn_expect_t;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	word_t error_vector;
	logic out_valid;
	logic out_stall = 1'b0;
	syn_t syndrome;
	logic cfg_valid;
	logic cfg_ready;
	word_t matrix_seed;

	word_t row_copy [ROW_COUNT_DEF];
	word_t seed_copy;
	syn_expect_t syn_q [$];
	int mismatches = 0;
	int cycle_count = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;

	seeded_parity_check_syndrome i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.error_vector(error_vector),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.syndrome(syndrome),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.matrix_seed(matrix_seed)
	);

	always #CLK_HALF clk = ~clk;

	// Row generator of the predictor

	function automatic word_t spin_left(input word_t x, input int k);
		return (x << k) | (x >> (WORD_W - k));
	endfunction

	function automatic word_t fold_mix(input word_t a, input word_t b);
		word_t ab;
		ab = a ^ b;
		return ab ^ spin_left(ab, 1) ^ spin_left(ab, WORD_W - 1);
	endfunction

	function automatic word_t grow_row(input word_t seed, input int idx);
		word_t acc;
		acc = spin_left(seed ^ word_t'(idx), 4);
		for (int k = 0; k < REVOLVE_STEPS_DEF; k++)
			acc = fold_mix(acc, seed) ^ spin_left(acc + seed, 8);
		return acc;
	endfunction

	function automatic void regen_rows(input word_t seed);
		seed_copy = seed;
		for (int i = 0; i < ROW_COUNT_DEF; i++)
			row_copy[i] = grow_row(seed, i);
	endfunction

	function automatic syn_t predict_syndrome(input word_t vec);
		syn_t s;
		s = '0;
		for (int i = 0; i < ROW_COUNT_DEF && i < SYN_W; i++)
			s[i] = ^(row_copy[i] & vec);
		return s;
	endfunction

	function automatic word_t pick_vector();
		word_t v;
		case ($urandom_range(3))
			0: v = $urandom;
			1: v = (word_t'(1) << $urandom_range(31)) | (word_t'(1) << $urandom_range(31));
			2: v = ~((word_t'(1) << $urandom_range(31)) | (word_t'(1) << $urandom_range(31)));
			default: v = $urandom & ({$urandom} << $urandom_range(31));
		endcase
		return v;
	endfunction

	function automatic word_t pick_seed();
		word_t s;
		case ($urandom_range(3))
			0: s = $urandom_range(31);
			1: s = ~word_t'($urandom_range(31));
			default: s = $urandom;
		endcase
		return s;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("ERROR @%0t: %s", $time, msg);
		mismatches++;
	endtask

	// Shared drivers

	task automatic send_vector(input word_t vec);
		cfg_valid <= 1'b0;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		error_vector <= vec;
		do @(posedge clk); while (in_stall);
		syn_q.push_back('{vec: vec, syn: predict_syndrome(vec)});
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (syn_q.size() != 0)
			@(posedge clk);
	endtask

	// Leaves cfg_valid high so back-to-back writes need no gap; the next send lowers it.
	task automatic write_seed(input word_t seed);
		wait_idle();
		cfg_valid <= 1'b1;
		matrix_seed <= seed;
		do @(posedge clk); while (!cfg_ready);
		regen_rows(seed);
	endtask

	// Result checker

	always @(posedge clk) begin
		syn_expect_t head;
		if (arst_n && out_valid && !out_stall) begin
			if (syn_q.size() == 0) begin
				report_mismatch($sformatf("unexpected syndrome %h", syndrome));
			end else begin
				head = syn_q.pop_front();
				if (syndrome !== head.syn)
					report_mismatch($sformatf("seed %h vector %h: syndrome %h, want %h",
						seed_copy, head.vec, syndrome, head.syn));
			end
		end
	end

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d syndromes outstanding",
				cycle_count, syn_q.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Tests

	task automatic test_reset_rows();
		send_vector('0);
		send_vector('1);
		send_vector(32'h0000_0001);
		send_vector(32'h8000_0000);
		send_vector(32'hAAAA_AAAA);
		send_vector(32'h5555_5555);
	endtask

	task automatic test_seed_extremes();
		write_seed('1);
		send_vector('0);
		send_vector('1);
		send_vector(32'hFFFF_0000);
		send_vector(32'h0000_FFFF);
		write_seed(32'h0000_0001);
		send_vector('1);
		send_vector(32'h8000_0001);
		write_seed(32'h8000_0000);
		send_vector('1);
		send_vector(32'h0F0F_F0F0);
		// back-to-back writes restart the rebuild; only the last seed counts
		write_seed(32'h1234_5678);
		write_seed(32'hDEAD_BEEF);
		write_seed('0);
		send_vector('1);
		send_vector(32'h0000_0100);
		write_seed(32'hA5A5_5A5A);
		send_vector('1);
		send_vector(32'hC3C3_3C3C);
	endtask

	task automatic test_random_traffic(input int idle_pct, input int stall_pct,
		input int count);
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		for (int n = 0; n < count; n++) begin
			if (n % SEED_EVERY == SEED_EVERY - 1)
				write_seed(pick_seed());
			send_vector(pick_vector());
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		error_vector = '0;
		cfg_valid = 1'b0;
		matrix_seed = '0;
		regen_rows('0);
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 11;
		recv_stall_pct = 63;
		test_reset_rows();
		test_seed_extremes();
		test_random_traffic(11, 63, RANDOM_ITEMS / 3);
		test_random_traffic(63, 11, RANDOM_ITEMS / 3);
		test_random_traffic(0, 0, RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));

		wait_idle();
		cfg_valid <= 1'b0;
		repeat (TAIL_CYCLES) @(posedge clk);
		if (syn_q.size() != 0)
			report_mismatch($sformatf("%0d syndromes never arrived", syn_q.size()));
		if (mismatches == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

// File: seeded_parity_check_syndrome.f
hdl/spc_pkg.sv
hdl/spc_row_gen.sv
hdl/spc_syndrome.sv
hdl/seeded_parity_check_syndrome.sv
tb/sv/testbench.sv
